// File: src/isqrt_pkg.sv
// shared constants and types for the integer square root block
`timescale 1ns / 1ps
`default_nettype none
package isqrt_pkg;

	localparam int RADICAND_BITS_DEF = 32;
	localparam int ROOT_FIELD_BITS   = 16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} isqrt_cmd_t;

endpackage
`default_nettype wire

// File: src/isqrt_dp.sv
// datapath of the integer square root: restoring digit recurrence, one root bit per step
`timescale 1ns / 1ps
`default_nettype none
module isqrt_dp #(
	parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire isqrt_pkg::isqrt_cmd_t                 cmd,
	input  wire logic [RADICAND_BITS-1:0]              radicand,
	output logic      [isqrt_pkg::ROOT_FIELD_BITS-1:0] root
);
	import isqrt_pkg::*;

	localparam int RootBits = (RADICAND_BITS + 1) / 2;
	localparam int PadBits  = 2 * RootBits;
	localparam int ExtBits  = (RootBits > ROOT_FIELD_BITS) ? RootBits : ROOT_FIELD_BITS;

	logic [PadBits-1:0]    rad_q;
	logic [RootBits:0]     rem_q;
	logic [RootBits-1:0]   root_q;
	logic [ROOT_FIELD_BITS-1:0] root_out_q;

	logic [RootBits+1:0]   rem_shift;
	logic [RootBits+1:0]   trial;
	logic [RootBits+1:0]   diff;
	logic                  fits;
	logic [ExtBits-1:0]    root_ext;

	// bring down the next two radicand bits and try root*4+1
	assign rem_shift = {rem_q[RootBits-1:0], rad_q[PadBits-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign fits      = (rem_shift >= trial);
	assign diff      = rem_shift - trial;
	assign root_ext  = ExtBits'(root_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			root_out_q <= root_ext[ROOT_FIELD_BITS-1:0];
		end
		if (cmd.load) begin
			rad_q  <= PadBits'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? diff[RootBits:0] : rem_shift[RootBits:0];
			// shift the new root bit in from the bottom
			root_q <= RootBits'({root_q, fits});
		end
	end

	assign root = root_out_q;

endmodule
`default_nettype wire

// File: src/isqrt_ctrl.sv
// controller of the integer square root: sequencing, step count and result handshake
`timescale 1ns / 1ps
`default_nettype none
module isqrt_ctrl #(
	parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output isqrt_pkg::isqrt_cmd_t      cmd
);
	import isqrt_pkg::*;

	localparam int RootBits = (RADICAND_BITS + 1) / 2;
	localparam int CntW     = (RootBits > 1) ? $clog2(RootBits) : 1;
	localparam logic [CntW-1:0] LastCnt = CntW'(RootBits - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;
	logic            can_emit;
	logic            accept;

	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && can_emit);
	assign accept   = in_valid && in_ready;

	assign cmd.load = accept;
	assign cmd.step = (state_q == ST_RUN);
	assign cmd.emit = (state_q == ST_FINISH) && can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= LastCnt;
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q - CntW'(1);
					end
				end
				ST_FINISH: begin
					if (can_emit) begin
						if (accept) begin
							state_q <= ST_RUN;
							cnt_q   <= LastCnt;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: src/integer_square_root_top.sv
// top level of the integer square root block
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata : radicand (bits RADICAND_BITS-1:0)
//  m_*      out  m_tvalid/m_tready  m_tdata : root (bits 15:0)
//
// each request takes RADICAND_BITS/2 (rounded up) iterations of one shared
// compare-subtract unit, one root bit per cycle, followed by a load of the
// result register
// a new request is taken in the same cycle the previous result is loaded
// the result register holds while m_tready is low; the next request is then
// computed but waits before loading until the register is free
// reset is asynchronous, active low, and clears the controller only
`timescale 1ns / 1ps
`default_nettype none
module integer_square_root_top #(
	parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((RADICAND_BITS+7)/8)*8-1:0]    s_tdata,  // radicand
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic      [isqrt_pkg::ROOT_FIELD_BITS-1:0] m_tdata   // root
);
	import isqrt_pkg::*;

	isqrt_cmd_t cmd;

	// sequencing and the result handshake
	isqrt_ctrl #(
		.RADICAND_BITS(RADICAND_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd)
	);

	// bits above the radicand width are ignored
	isqrt_dp #(
		.RADICAND_BITS(RADICAND_BITS)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.radicand(s_tdata[RADICAND_BITS-1:0]),
		.root    (m_tdata)
	);

endmodule
`default_nettype wire

// File: src/isqrt_check.sv
// port checker for the integer square root block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module isqrt_check #(
	parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF
) (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  s_tvalid,
	input wire logic                                  s_tready,
	input wire logic [((RADICAND_BITS+7)/8)*8-1:0]    s_tdata,
	input wire logic                                  m_tvalid,
	input wire logic                                  m_tready,
	input wire logic [isqrt_pkg::ROOT_FIELD_BITS-1:0] m_tdata
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// a waiting result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no back-to-back acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a new result is loaded only after a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready, 2))
		else $error("result appeared without computation");

	// a waiting request keeps its radicand
	a_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> $stable(s_tdata))
		else $error("request changed while waiting");

endmodule

bind integer_square_root_top isqrt_check #(
	.RADICAND_BITS(RADICAND_BITS)
) u_isqrt_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

// File: bench/integer_square_root_checker.sv
// request and result checker for the integer square root block
`timescale 1ns / 1ps
module integer_square_root_checker #(
	parameter int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	input  wire logic                                  s_tready,
	input  wire logic [((RADICAND_BITS+7)/8)*8-1:0]    s_tdata,  // radicand
	input  wire logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	input  wire logic [isqrt_pkg::ROOT_FIELD_BITS-1:0] m_tdata,  // root
	output int                                         failures,
	output int                                         outstanding
);

	localparam int ROOT_BITS = isqrt_pkg::ROOT_FIELD_BITS;

	logic [ROOT_BITS-1:0] root_queue[$];

	// restoring digit recurrence, one root bit per pass, low root bits kept
	function automatic logic [ROOT_BITS-1:0] floor_sqrt(
		input logic [((RADICAND_BITS+7)/8)*8-1:0] data
	);
		logic [63:0] rem_acc;
		logic [63:0] root_acc;
		logic [63:0] probe;
		rem_acc = 64'(data);
		if (RADICAND_BITS < 64) begin
			rem_acc = rem_acc & ((64'd1 << RADICAND_BITS) - 64'd1);
		end
		root_acc = '0;
		probe = 64'd1 << 62;
		while (probe > rem_acc) begin
			probe = probe >> 2;
		end
		while (probe != 0) begin
			if (rem_acc >= root_acc + probe) begin
				rem_acc = rem_acc - (root_acc + probe);
				root_acc = (root_acc >> 1) + probe;
			end else begin
				root_acc = root_acc >> 1;
			end
			probe = probe >> 2;
		end
		return root_acc[ROOT_BITS-1:0];
	endfunction

	always @(posedge clk) begin
		logic [ROOT_BITS-1:0] wanted;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				root_queue.insert(root_queue.size(), floor_sqrt(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (root_queue.size() == 0) begin
					$error("root: result with no request pending, got %0d", m_tdata);
					failures <= failures + 1;
				end else begin
					wanted = root_queue.pop_front();
					if (m_tdata !== wanted) begin
						$error("root mismatch: expected %0d, got %0d", wanted, m_tdata);
						failures <= failures + 1;
					end
				end
			end
			outstanding <= root_queue.size();
		end
	end

endmodule

// File: bench/integer_square_root_top_test.sv
// testbench top for the integer square root block: stimulus and verdict
`timescale 1ns / 1ps
module integer_square_root_top_test;

	localparam int RADICAND_BITS = isqrt_pkg::RADICAND_BITS_DEF;
	localparam int DATA_BITS     = ((RADICAND_BITS + 7) / 8) * 8;
	localparam int ROOT_BITS     = isqrt_pkg::ROOT_FIELD_BITS;
	localparam int RANDOM_COUNT  = 1100;
	localparam int BLOCK_COUNT   = 100;
	localparam int MAX_GAP       = 19;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [ROOT_BITS-1:0] m_tdata;

	int failures;
	int outstanding;

	// when set, neither side idles: back-to-back requests and results
	logic no_idle = 1'b0;

	integer_square_root_top #(
		.RADICAND_BITS(RADICAND_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	integer_square_root_checker #(
		.RADICAND_BITS(RADICAND_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.failures   (failures),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// hard stop: reports a failure and ends the run if it has not finished
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// idle cycles before the next request or result, none in burst stretches
	function automatic int draw_gap();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// random radicand: some full-range, some scaled down, half at or near perfect squares
	function automatic logic [DATA_BITS-1:0] pick_radicand();
		logic [63:0] wide;
		logic [63:0] base;
		int          kind;
		wide = {$urandom(), $urandom()};
		base = 64'($urandom_range(0, 65535));
		kind = $urandom_range(0, 5);
		case (kind)
			0, 1: begin
			end
			2: begin
				wide = wide >> $urandom_range(0, 63);
			end
			3: begin
				wide = base * base;
			end
			4: begin
				// one below a perfect square, where the root steps down
				if (base == 0) begin
					base = 1;
				end
				wide = base * base - 64'd1;
			end
			default: begin
				wide = base * base + 64'($urandom_range(0, 32'(2 * base)));
			end
		endcase
		return wide[DATA_BITS-1:0];
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_radicand(input logic [DATA_BITS-1:0] value);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			// invalid data on the bus while idle must be ignored
			s_tvalid <= 1'b0;
			s_tdata  <= DATA_BITS'({$urandom(), $urandom()});
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// result side: a fresh stall for every result, then ready until it is taken
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		logic [DATA_BITS-1:0] directed[$];
		int                   sent;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero and one, small squares and their neighbours, field extremes,
		// the largest square that fits and alternating bit patterns
		directed = '{
			DATA_BITS'(0), DATA_BITS'(1), DATA_BITS'(2), DATA_BITS'(3),
			DATA_BITS'(4), DATA_BITS'(8), DATA_BITS'(15), DATA_BITS'(16),
			DATA_BITS'(24), DATA_BITS'(25), DATA_BITS'(255), DATA_BITS'(256),
			DATA_BITS'(65535), DATA_BITS'(65536), DATA_BITS'(999999),
			DATA_BITS'(1000000), DATA_BITS'(32'h3FFF_FFFF), DATA_BITS'(32'h4000_0000),
			DATA_BITS'(32'h8000_0000), DATA_BITS'(32'h5555_5555),
			DATA_BITS'(32'hAAAA_AAAA), DATA_BITS'(32'hFFFE_0000),
			DATA_BITS'(32'hFFFE_0001), DATA_BITS'(32'hFFFF_FFFE), {DATA_BITS{1'b1}}
		};
		foreach (directed[i]) begin
			send_radicand(directed[i]);
		end
		drain_results();

		// random part in blocks, some of them run with no idling at all
		sent = 0;
		while (sent < RANDOM_COUNT) begin
			no_idle <= ($urandom_range(0, 3) == 0);
			repeat (BLOCK_COUNT) begin
				send_radicand(pick_radicand());
				sent++;
			end
			// one mid-run pause with everything drained
			if (sent == 5 * BLOCK_COUNT) begin
				drain_results();
			end
		end
		no_idle <= 1'b0;

		drain_results();
		// settle time to catch stray results
		repeat (40) @(posedge clk);

		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: integer_square_root_top.f
src/isqrt_pkg.sv
src/isqrt_dp.sv
src/isqrt_ctrl.sv
src/integer_square_root_top.sv
src/isqrt_check.sv
bench/integer_square_root_checker.sv
bench/integer_square_root_top_test.sv
